### src/lzwe_pkg.sv
// Shared constants, types and state encoding for the LZW byte stream encoder.
package lzwe_pkg;

    localparam int DICT_ENTRIES = 256;

    localparam int CODE_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int KEY_W   = CODE_W + BYTE_W;
    localparam int LIMIT_W = 9;
    localparam int CNT_W   = $clog2(DICT_ENTRIES + 1);
    localparam int LIM_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam int GROUP_SIZE  = 16;
    localparam int GROUP_LOW_W = 4;
    localparam int NUM_GROUPS  = (DICT_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_W       = NUM_GROUPS * GROUP_SIZE;
    localparam int GRP_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int TREE_IDX_W  = GRP_W + GROUP_LOW_W;

    localparam logic [CODE_W-1:0]  CODE_CLEAR       = 12'd256;
    localparam logic [CODE_W-1:0]  CODE_END         = 12'd257;
    localparam logic [CODE_W-1:0]  CODE_FIRST_ENTRY = 12'd258;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 9'd256;
    localparam logic               MODE_END         = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK1,
        ST_LOOK2,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                  hit;
        logic [TREE_IDX_W-1:0] idx;
    } t_hit;

endpackage

### src/lzwe_cell.sv
// One dictionary cell: holds a (prefix, byte) pair and registers its match against the key.
module lzwe_cell
    import lzwe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_live,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_match
);

    logic [KEY_W-1:0] r_entry;
    logic             r_match;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_entry <= i_key;
        end
        r_match <= i_live && (r_entry == i_key);
    end

    assign o_match = r_match;

endmodule

### src/lzwe_hit_tree.sv
// Two-level reduction of the cell match bits into a hit flag and an entry index.
module lzwe_hit_tree
    import lzwe_pkg::*;
(
    input  logic                    i_clk,
    input  logic [DICT_ENTRIES-1:0] i_match,
    output t_hit                    o_res
);

    logic [PAD_W-1:0]       w_pad;
    logic                   r_grp_hit [NUM_GROUPS];
    logic [GROUP_LOW_W-1:0] r_grp_low [NUM_GROUPS];
    logic                   n_grp_hit [NUM_GROUPS];
    logic [GROUP_LOW_W-1:0] n_grp_low [NUM_GROUPS];

    assign w_pad = PAD_W'(i_match);

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_grp_hit[g] = 1'b0;
            n_grp_low[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (w_pad[g * GROUP_SIZE + k]) begin
                    n_grp_hit[g] = 1'b1;
                    n_grp_low[g] = n_grp_low[g] | GROUP_LOW_W'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            r_grp_hit[g] <= n_grp_hit[g];
            r_grp_low[g] <= n_grp_low[g];
        end
    end

    always_comb begin
        o_res.hit = 1'b0;
        o_res.idx = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (r_grp_hit[g]) begin
                o_res.hit = 1'b1;
                o_res.idx = o_res.idx | {GRP_W'(g), r_grp_low[g]};
            end
        end
    end

endmodule

### src/lzw_byte_stream_encoder_unit.sv
// Top level of the LZW byte stream encoder: control, dictionary cell row and output stage.
//
// The block takes one beat at a time and holds its input stalled until that beat's codes
// are loaded into the output register. A first byte after start, clear or end only becomes
// the prefix. A later byte runs the dictionary lookup (key register, match register in
// every cell, group register of the match reduction, decision), and a miss then sends one
// code, or three on a forced clear, one per cycle while the output is not stalled. An end
// beat sends one or two codes. The lookup latency is set by the registered match in each
// cell and the two-level match reduction. The dictionary needs no clearing pass after
// reset; dict_limit is taken at any time and should only change while the block is idle.
module lzw_byte_stream_encoder_unit
    import lzwe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [BYTE_W-1:0]  i_byte_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [CODE_W-1:0]  o_code,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_dict_limit
);

    t_state              r_state, n_state;
    logic                r_has_pending, n_has_pending;
    logic [CODE_W-1:0]   r_pending, n_pending;
    logic [CNT_W-1:0]    r_entry_count, n_entry_count;
    logic [LIMIT_W-1:0]  r_dict_limit;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [CODE_W-1:0]   r_q_code [3];
    logic [CODE_W-1:0]   n_q_code [3];
    logic [1:0]          r_q_cnt, n_q_cnt;
    logic                r_out_valid, n_out_valid;
    logic [CODE_W-1:0]   r_out_code, n_out_code;
    logic                r_out_last, n_out_last;

    logic                    w_in_accept;
    logic                    w_out_free;
    logic                    w_stall;
    logic                    w_write;
    logic                    w_emit_load;
    logic [DICT_ENTRIES-1:0] w_live;
    logic [DICT_ENTRIES-1:0] w_we;
    logic [DICT_ENTRIES-1:0] w_match;
    t_hit                    w_res;
    logic [LIM_W-1:0]        w_limit;
    logic [LIM_W-1:0]        w_count_inc;
    logic                    w_force;

    assign w_in_accept = i_in_valid && !w_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Cell row.
    for (genvar gi = 0; gi < DICT_ENTRIES; gi++) begin : g_cell
        assign w_live[gi] = CNT_W'(gi) < r_entry_count;
        assign w_we[gi]   = w_write && (r_entry_count == CNT_W'(gi));

        lzwe_cell u_cell (
            .i_clk   (i_clk),
            .i_we    (w_we[gi]),
            .i_live  (w_live[gi]),
            .i_key   (r_key),
            .o_match (w_match[gi])
        );
    end

    lzwe_hit_tree u_hit_tree (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_res   (w_res)
    );

    always_comb begin
        w_limit = LIM_W'(r_dict_limit);
        if (w_limit == '0) begin
            w_limit = LIM_W'(1);
        end
        if (w_limit > LIM_W'(DICT_ENTRIES)) begin
            w_limit = LIM_W'(DICT_ENTRIES);
        end
        w_count_inc = LIM_W'(r_entry_count) + LIM_W'(1);
        w_force     = w_count_inc >= w_limit;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    if (i_mode == MODE_END) begin
                        n_state = ST_EMIT;
                    end else if (r_has_pending) begin
                        n_state = ST_LOOK1;
                    end
                end
            end
            ST_LOOK1: n_state = ST_LOOK2;
            ST_LOOK2: n_state = ST_DECIDE;
            ST_DECIDE: begin
                n_state = w_res.hit ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (w_emit_load && (r_q_cnt == 2'd1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        w_stall     = 1'b1;
        w_write     = 1'b0;
        w_emit_load = 1'b0;
        case (r_state)
            ST_IDLE:   w_stall = 1'b0;
            ST_DECIDE: w_write = !w_res.hit;
            ST_EMIT:   w_emit_load = w_out_free && (r_q_cnt != 2'd0);
            default: begin
                w_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_has_pending = r_has_pending;
        n_pending     = r_pending;
        n_entry_count = r_entry_count;
        n_key         = r_key;
        n_q_code      = r_q_code;
        n_q_cnt       = r_q_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    if (i_mode == MODE_END) begin
                        if (r_has_pending) begin
                            n_q_code[0] = r_pending;
                            n_q_code[1] = CODE_END;
                            n_q_cnt     = 2'd2;
                        end else begin
                            n_q_code[0] = CODE_END;
                            n_q_cnt     = 2'd1;
                        end
                        n_has_pending = 1'b0;
                        n_entry_count = '0;
                    end else if (!r_has_pending) begin
                        n_pending     = CODE_W'(i_byte_value);
                        n_has_pending = 1'b1;
                        n_entry_count = '0;
                    end else begin
                        n_key = {r_pending, i_byte_value};
                    end
                end
            end
            ST_DECIDE: begin
                if (w_res.hit) begin
                    n_pending = CODE_FIRST_ENTRY + CODE_W'(w_res.idx);
                end else begin
                    n_q_code[0] = r_pending;
                    n_q_code[1] = CODE_W'(r_key[BYTE_W-1:0]);
                    n_q_code[2] = CODE_CLEAR;
                    n_pending   = CODE_W'(r_key[BYTE_W-1:0]);
                    if (w_force) begin
                        n_q_cnt       = 2'd3;
                        n_entry_count = '0;
                        n_has_pending = 1'b0;
                    end else begin
                        n_q_cnt       = 2'd1;
                        n_entry_count = CNT_W'(w_count_inc);
                    end
                end
            end
            ST_EMIT: begin
                if (w_emit_load) begin
                    n_q_code[0] = r_q_code[1];
                    n_q_code[1] = r_q_code[2];
                    n_q_cnt     = r_q_cnt - 2'd1;
                end
            end
            default: begin
                n_q_cnt = r_q_cnt;
            end
        endcase

        n_out_valid = r_out_valid;
        n_out_code  = r_out_code;
        n_out_last  = r_out_last;
        if (w_emit_load) begin
            n_out_valid = 1'b1;
            n_out_code  = r_q_code[0];
            n_out_last  = (r_q_cnt == 2'd1);
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_has_pending <= 1'b0;
            r_pending     <= '0;
            r_entry_count <= '0;
            r_q_cnt       <= '0;
            r_out_valid   <= 1'b0;
            r_dict_limit  <= LIMIT_RESET;
        end else begin
            r_state       <= n_state;
            r_has_pending <= n_has_pending;
            r_pending     <= n_pending;
            r_entry_count <= n_entry_count;
            r_q_cnt       <= n_q_cnt;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid) begin
                r_dict_limit <= i_dict_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_q_code   <= n_q_code;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    assign o_in_stall  = w_stall;
    assign o_out_valid = r_out_valid;
    assign o_code      = r_out_code;
    assign o_last      = r_out_last;
    assign o_cfg_ready = 1'b1;

endmodule

### test/tb_top.sv
// Self-checking testbench for the LZW byte stream encoder, with its own encoder model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lzwe_pkg::*;

    localparam logic MODE_DATA     = ~MODE_END;
    localparam int   IDLE_PCT      = 22;
    localparam int   SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_code_beat;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic               i_mode       = 1'b0;
    logic [BYTE_W-1:0]  i_byte_value = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic [CODE_W-1:0]  o_code;
    logic               o_last;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [LIMIT_W-1:0] i_dict_limit = LIMIT_RESET;

    t_code_beat         code_queue[$];
    logic [KEY_W-1:0]   dict_model[DICT_ENTRIES];
    int                 entries_used  = 0;
    logic [CODE_W-1:0]  prefix_code   = '0;
    bit                 prefix_valid  = 1'b0;
    logic [LIMIT_W-1:0] limit_model   = LIMIT_RESET;
    bit                 quiet         = 1'b0;
    int                 errors        = 0;
    int                 beats_sent    = 0;
    int                 codes_checked = 0;
    int                 clears_forced = 0;
    int                 dict_hits     = 0;
    int                 end_marks     = 0;

    lzw_byte_stream_encoder_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_byte_value (i_byte_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code       (o_code),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_dict_limit (i_dict_limit)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    function automatic void encode_beat(input logic mode, input logic [BYTE_W-1:0] data);
        logic [CODE_W-1:0] emitted[3];
        logic [KEY_W-1:0]  key;
        int                n;
        int                i;
        int                hit_idx;
        int                lim;
        n = 0;
        hit_idx = -1;
        if (mode == MODE_END) begin
            if (prefix_valid) begin
                emitted[n] = prefix_code;
                n++;
            end
            emitted[n] = CODE_END;
            n++;
            prefix_valid = 1'b0;
            entries_used = 0;
            end_marks++;
        end else if (!prefix_valid) begin
            prefix_code  = CODE_W'(data);
            prefix_valid = 1'b1;
            entries_used = 0;
        end else begin
            key = {prefix_code, data};
            for (i = 0; i < entries_used && i < DICT_ENTRIES; i++) begin
                if (hit_idx < 0 && dict_model[i] == key) begin
                    hit_idx = i;
                end
            end
            if (hit_idx >= 0) begin
                prefix_code = CODE_FIRST_ENTRY + CODE_W'(hit_idx);
                dict_hits++;
            end else begin
                if (entries_used < DICT_ENTRIES) begin
                    dict_model[entries_used] = key;
                end
                entries_used++;
                emitted[n] = prefix_code;
                n++;
                prefix_code = CODE_W'(data);
                lim = int'(limit_model);
                if (lim < 1) begin
                    lim = 1;
                end
                if (lim > DICT_ENTRIES) begin
                    lim = DICT_ENTRIES;
                end
                if (entries_used >= lim) begin
                    emitted[n] = CODE_W'(data);
                    n++;
                    emitted[n] = CODE_CLEAR;
                    n++;
                    entries_used = 0;
                    prefix_valid = 1'b0;
                    clears_forced++;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            code_queue.push_back('{code: emitted[i], last: (i == n - 1)});
        end
    endfunction

    task automatic send_beat(input logic mode, input logic [BYTE_W-1:0] data);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_byte_value <= data;
        do @(posedge i_clk); while (o_in_stall);
        encode_beat(mode, data);
        beats_sent++;
    endtask

    task automatic drain_codes();
        i_in_valid <= 1'b0;
        while (code_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dict_limit(input logic [LIMIT_W-1:0] value);
        drain_codes();
        i_cfg_valid  <= 1'b1;
        i_dict_limit <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_model = value;
    endtask

    task automatic send_stream(input int length, input int alphabet, input bit close);
        logic [BYTE_W-1:0] base;
        int                k;
        base = BYTE_W'($urandom_range(255));
        for (k = 0; k < length; k++) begin
            if ($urandom_range(99) < 5) begin
                send_beat(MODE_END, BYTE_W'($urandom_range(255)));
            end else begin
                send_beat(MODE_DATA, base + BYTE_W'($urandom_range(alphabet - 1)));
            end
        end
        if (close) begin
            send_beat(MODE_END, BYTE_W'($urandom_range(255)));
        end
    endtask

    task automatic test_start_and_end();
        send_beat(MODE_END, 8'hFF);
        send_beat(MODE_DATA, 8'h00);
        send_beat(MODE_DATA, 8'hFF);
        send_beat(MODE_END, 8'h00);
    endtask

    task automatic test_dictionary_hits();
        int k;
        for (k = 0; k < 6; k++) begin
            send_beat(MODE_DATA, k[0] ? 8'hAA : 8'h55);
        end
        send_beat(MODE_END, 8'h55);
    endtask

    task automatic test_forced_clear();
        write_dict_limit(9'd1);
        send_beat(MODE_DATA, 8'h12);
        send_beat(MODE_DATA, 8'h34);
        send_beat(MODE_DATA, 8'h56);
        send_beat(MODE_END, 8'hFF);
        write_dict_limit(9'd0);
        send_beat(MODE_DATA, 8'h07);
        send_beat(MODE_DATA, 8'h07);
    endtask

    task automatic test_limit_lowered();
        int k;
        write_dict_limit(LIMIT_RESET);
        for (k = 1; k <= 4; k++) begin
            send_beat(MODE_DATA, BYTE_W'(k));
        end
        // Three entries are in use when the limit drops to two.
        write_dict_limit(9'd2);
        send_beat(MODE_DATA, 8'h05);
    endtask

    task automatic test_random_streams();
        logic [LIMIT_W-1:0] limits[7];
        int                 s;
        int                 sent_here;
        int                 len;
        int                 alphabet;
        limits = '{9'd2, 9'd5, 9'd16, 9'd64, 9'd255, 9'd0, LIMIT_RESET};
        for (s = 0; s < 7; s++) begin
            write_dict_limit(limits[s]);
            sent_here = 0;
            while (sent_here < 22) begin
                case ($urandom_range(4))
                    0: alphabet = 2;
                    1: alphabet = 3;
                    2: alphabet = 4;
                    3: alphabet = 16;
                    default: alphabet = 256;
                endcase
                len = $urandom_range(30, 1);
                send_stream(len, alphabet, $urandom_range(99) < 85);
                sent_here += len + 1;
                if ($urandom_range(9) == 0) begin
                    drain_codes();
                end
            end
        end
    endtask

    task automatic test_full_table();
        int guard;
        int clears_at_start;
        write_dict_limit(9'h1FF);
        quiet = 1'b1;
        guard = 0;
        clears_at_start = clears_forced;
        while (clears_forced == clears_at_start && guard < 600) begin
            send_beat(MODE_DATA, BYTE_W'($urandom_range(255)));
            guard++;
        end
        send_beat(MODE_DATA, BYTE_W'($urandom_range(255)));
        send_beat(MODE_END, BYTE_W'($urandom_range(255)));
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_code_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (code_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected code %0d last %0b", $time, o_code, o_last);
            end else begin
                want = code_queue.pop_front();
                codes_checked++;
                if (o_code !== want.code) begin
                    errors++;
                    $display("%0t: code expected %0d actual %0d", $time, want.code, o_code);
                end
                if (o_last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last);
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_start_and_end();
        test_dictionary_hits();
        test_forced_clear();
        test_limit_lowered();
        test_random_streams();
        test_full_table();
        drain_codes();
        if (code_queue.size() != 0) begin
            errors++;
        end
        $display("Sent %0d beats and checked %0d codes; %0d hits, %0d clears, %0d end beats.",
                 beats_sent, codes_checked, dict_hits, clears_forced, end_marks);
        $display("Dictionary limits from 0 to 511 were used, one lowered mid stream.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
